FILE: rtl/flwm_pkg.sv
`default_nettype none
package flwm_pkg;

  localparam int MAX_COMPONENTS    = 4;
  localparam int LOCAL_SUBMAPS     = 16;
  localparam int MAX_SUBMAP_PIXELS = 1024;
  localparam int GLOBAL_SUBMAPS    = 1024;
  localparam int SLOT_COUNT        = LOCAL_SUBMAPS * MAX_SUBMAP_PIXELS;
  localparam int SLOT_W            = $clog2(SLOT_COUNT);
  localparam int GSUB_W            = $clog2(GLOBAL_SUBMAPS);
  localparam int LOCAL_W           = $clog2(LOCAL_SUBMAPS);
  localparam int PIX_W             = 20;
  localparam int SIZE_W            = 11;
  localparam int ACC_W             = 64;

  typedef enum logic [1:0] {
    ACT_ACCUM = 2'd0,
    ACT_TABLE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DET_FLAG = 3'd1,
    ST_SHR_FLAG = 3'd2,
    ST_BAD_PIX  = 3'd3,
    ST_UNMAPPED = 3'd4,
    ST_TBL_WR   = 3'd5,
    ST_READ     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_COUNT    = 3'd0,
    REG_SIZE     = 3'd1,
    REG_DET_MASK = 3'd2,
    REG_SHR_MASK = 3'd3,
    REG_DET_EN   = 3'd4,
    REG_SHR_EN   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic              load;
    logic              mul_lo;
    logic              mul_hi;
    logic              term;
    logic              rd;
    logic              wr;
    logic              clr;
    logic [SLOT_W-1:0] addr;
  } lane_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/flwm_ram.sv
`default_nettype none
module flwm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/flwm_div.sv
`default_nettype none
module flwm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [flwm_pkg::PIX_W-1:0]    dividend,
  input  wire logic [flwm_pkg::SIZE_W-1:0]   divisor,
  output logic                               done,
  output logic      [flwm_pkg::PIX_W-1:0]    quo,
  output logic      [flwm_pkg::SIZE_W-1:0]   rem
);

  localparam int CNT_W = $clog2(flwm_pkg::PIX_W);

  logic                          run_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [flwm_pkg::PIX_W-1:0]    quo_r;
  logic [flwm_pkg::SIZE_W-1:0]   rem_r;
  logic [flwm_pkg::SIZE_W-1:0]   dvs_r;
  logic [flwm_pkg::SIZE_W:0]     trial;
  logic [flwm_pkg::SIZE_W:0]     diff;
  logic                          fits;

  assign trial = {rem_r, quo_r[flwm_pkg::PIX_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(flwm_pkg::PIX_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[flwm_pkg::PIX_W-2:0], fits};
      rem_r <= fits ? diff[flwm_pkg::SIZE_W-1:0] : trial[flwm_pkg::SIZE_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

FILE: rtl/flwm_lane.sv
`default_nettype none
module flwm_lane (
  input  wire logic                          clk,
  input  wire flwm_pkg::lane_ctrl_t          ctrl,
  input  wire logic                          enable,
  input  wire logic signed [31:0]            weight,
  input  wire logic [flwm_pkg::ACC_W-1:0]    a_mag,
  input  wire logic                          a_neg,
  output logic      [flwm_pkg::ACC_W-1:0]    rd_data
);

  localparam logic [63:0] MAX_POS = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MIN_NEG = {1'b1, {63{1'b0}}};

  logic [31:0] b_r;
  logic        wneg_r;
  logic [63:0] p0_r;
  logic [63:0] p1_r;
  logic [63:0] term_r;
  logic [63:0] q;
  logic [63:0] rnd;
  logic        neg;
  logic [63:0] term_nxt;
  logic [63:0] sum;
  logic [63:0] sat_sum;
  logic [63:0] wdata;

  assign rnd = p0_r + 64'(1 << 29);
  assign q   = (p1_r << 2) + {30'd0, rnd[63:30]};
  assign neg = a_neg ^ wneg_r;

  always_comb begin
    if (a_mag == '0 || b_r == '0) begin
      term_nxt = '0;
    end else if (neg) begin
      term_nxt = q[63] ? MIN_NEG : (~q + 64'd1);
    end else begin
      term_nxt = q[63] ? MAX_POS : q;
    end
  end

  assign sum = rd_data + term_r;

  always_comb begin
    if (rd_data[63] == term_r[63] && sum[63] != term_r[63]) begin
      sat_sum = term_r[63] ? MIN_NEG : MAX_POS;
    end else begin
      sat_sum = sum;
    end
  end

  assign wdata = ctrl.clr ? '0 : sat_sum;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      b_r    <= weight[31] ? (~weight + 32'd1) : weight;
      wneg_r <= weight[31];
    end
    if (ctrl.mul_lo) begin
      p0_r <= 64'(a_mag[31:0]) * 64'(b_r);
    end
    if (ctrl.mul_hi) begin
      p1_r <= 64'(a_mag[63:32]) * 64'(b_r);
    end
    if (ctrl.term) begin
      term_r <= term_nxt;
    end
  end

  flwm_ram #(
    .WIDTH(flwm_pkg::ACC_W),
    .DEPTH(flwm_pkg::SLOT_COUNT)
  ) u_acc_ram (
    .clk  (clk),
    .we   (ctrl.clr | (ctrl.wr & enable)),
    .waddr(ctrl.addr),
    .wdata(wdata),
    .re   (ctrl.rd),
    .raddr(ctrl.addr),
    .rdata(rd_data)
  );

endmodule
`default_nettype wire

FILE: rtl/flagged_weighted_map_accumulator.sv
`default_nettype none
// Accumulate: pixel divider, table read, two 32x32 partial products per lane, rounding,
// then RMW of the accumulator RAMs; the result strobe follows. Results cannot be stalled.
// Unmapped submap: ends after divide (submap past table) or table read (empty entry).
// Flag rejects, bad pixel, table writes: strobe the cycle after accept; reads add a RAM
// read state. Unused action: none. One item at a time; busy drops as the result shows.
// Reset: one pass clears accumulator RAMs and submap table; busy high until done.
module flagged_weighted_map_accumulator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [20:0] in_pixel,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic signed [31:0] in_gain,
  input  wire logic signed [31:0] in_weight_0,
  input  wire logic signed [31:0] in_weight_1,
  input  wire logic signed [31:0] in_weight_2,
  input  wire logic signed [31:0] in_weight_3,
  input  wire logic [7:0]         in_det_flag_bits,
  input  wire logic [7:0]         in_shared_flag_bits,
  input  wire logic [13:0]        in_entry_address,
  input  wire logic signed [4:0]  in_entry_value,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [10:0]        cfg_data,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic signed [63:0]      out_accum_0,
  output logic signed [63:0]      out_accum_1,
  output logic signed [63:0]      out_accum_2,
  output logic signed [63:0]      out_accum_3
);

  localparam int NL = flwm_pkg::MAX_COMPONENTS;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_DIV, S_TBL, S_MAP, S_HI, S_TERM, S_ADD
  } state_t;

  state_t st_r;
  logic [flwm_pkg::SLOT_W-1:0]  clr_cnt_r;
  logic [2:0]  cnt_cfg_r;
  logic [10:0] size_cfg_r;
  logic [7:0]  det_mask_r;
  logic [7:0]  shr_mask_r;
  logic        det_en_r;
  logic        shr_en_r;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [63:0]        out_acc_r [NL];
  logic signed [63:0] scaled_r;
  logic [63:0]        a_mag_r;
  logic [flwm_pkg::SLOT_W-1:0] slot_r;

  logic [flwm_pkg::SIZE_W-1:0] eff_size;
  logic [2:0]                  eff_count;
  logic                        accept;
  logic                        det_hit;
  logic                        shr_hit;
  logic                        div_start;
  logic                        div_done;
  logic [flwm_pkg::PIX_W-1:0]  quo;
  logic [flwm_pkg::SIZE_W-1:0] rem;
  logic                        tbl_we;
  logic [flwm_pkg::GSUB_W-1:0] tbl_waddr;
  logic [4:0]                  tbl_wdata;
  logic [4:0]                  tbl_rdata;
  logic [14:0]                 slot_calc;
  flwm_pkg::lane_ctrl_t        lctrl;
  logic [63:0]                 lane_rd [NL];
  logic signed [31:0]          weights [NL];

  assign weights[0] = in_weight_0;
  assign weights[1] = in_weight_1;
  assign weights[2] = in_weight_2;
  assign weights[3] = in_weight_3;

  always_comb begin
    if (size_cfg_r == '0) begin
      eff_size = 11'd1;
    end else if (size_cfg_r > 11'(flwm_pkg::MAX_SUBMAP_PIXELS)) begin
      eff_size = 11'(flwm_pkg::MAX_SUBMAP_PIXELS);
    end else begin
      eff_size = size_cfg_r;
    end
    if (cnt_cfg_r == '0) begin
      eff_count = 3'd1;
    end else if (cnt_cfg_r > 3'(NL)) begin
      eff_count = 3'(NL);
    end else begin
      eff_count = cnt_cfg_r;
    end
  end

  assign busy      = (st_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign det_hit   = det_en_r && ((in_det_flag_bits & det_mask_r) != '0);
  assign shr_hit   = shr_en_r && ((in_shared_flag_bits & shr_mask_r) != '0);
  assign div_start = accept && in_action == flwm_pkg::ACT_ACCUM && !det_hit && !shr_hit
                     && !in_pixel[20];

  assign slot_calc = 15'(tbl_rdata[3:0]) * 15'(eff_size) + 15'(rem);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = in_entry_address[flwm_pkg::GSUB_W-1:0];
    tbl_wdata = {~in_entry_value[4], in_entry_value[3:0]};
    if (st_r == S_CLR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_cnt_r[flwm_pkg::GSUB_W-1:0];
      tbl_wdata = '0;
    end else if (accept && in_action == flwm_pkg::ACT_TABLE
                 && in_entry_address[13:flwm_pkg::GSUB_W] == '0) begin
      tbl_we = 1'b1;
    end
  end

  always_comb begin
    lctrl        = '0;
    lctrl.addr   = slot_r;
    lctrl.load   = accept;
    lctrl.mul_lo = (st_r == S_MAP);
    lctrl.mul_hi = (st_r == S_HI);
    lctrl.term   = (st_r == S_TERM);
    lctrl.wr     = (st_r == S_ADD);
    unique case (st_r)
      S_CLR: begin
        lctrl.clr  = 1'b1;
        lctrl.addr = clr_cnt_r;
      end
      S_IDLE: begin
        lctrl.rd   = accept && in_action == flwm_pkg::ACT_READ;
        lctrl.addr = in_entry_address;
      end
      S_HI: lctrl.rd = 1'b1;
      default: ;
    endcase
  end

  flwm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(in_pixel[flwm_pkg::PIX_W-1:0]),
    .divisor (eff_size),
    .done    (div_done),
    .quo     (quo),
    .rem     (rem)
  );

  flwm_ram #(
    .WIDTH(5),
    .DEPTH(flwm_pkg::GLOBAL_SUBMAPS)
  ) u_tbl_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (st_r == S_TBL),
    .raddr(quo[flwm_pkg::GSUB_W-1:0]),
    .rdata(tbl_rdata)
  );

  for (genvar g = 0; g < NL; g++) begin : g_lane
    flwm_lane u_lane (
      .clk    (clk),
      .ctrl   (lctrl),
      .enable (3'(g) < eff_count),
      .weight (weights[g]),
      .a_mag  (a_mag_r),
      .a_neg  (scaled_r[63]),
      .rd_data(lane_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scaled_r <= 64'(in_sample_value) * 64'(in_gain);
    end
    a_mag_r <= scaled_r[63] ? (~scaled_r + 64'd1) : scaled_r;
    if (st_r == S_MAP) begin
      slot_r <= slot_calc[flwm_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_CLR;
      clr_cnt_r    <= '0;
      cnt_cfg_r    <= 3'd1;
      size_cfg_r   <= 11'd1024;
      det_mask_r   <= '0;
      shr_mask_r   <= '0;
      det_en_r     <= 1'b0;
      shr_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      out_status_r <= '0;
      for (int i = 0; i < NL; i++) begin
        out_acc_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          flwm_pkg::REG_COUNT:    cnt_cfg_r  <= cfg_data[2:0];
          flwm_pkg::REG_SIZE:     size_cfg_r <= cfg_data;
          flwm_pkg::REG_DET_MASK: det_mask_r <= cfg_data[7:0];
          flwm_pkg::REG_SHR_MASK: shr_mask_r <= cfg_data[7:0];
          flwm_pkg::REG_DET_EN:   det_en_r   <= cfg_data[0];
          flwm_pkg::REG_SHR_EN:   shr_en_r   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            for (int i = 0; i < NL; i++) begin
              out_acc_r[i] <= '0;
            end
            unique case (in_action)
              flwm_pkg::ACT_ACCUM: begin
                if (div_start) begin
                  st_r <= S_DIV;
                end else begin
                  out_valid_r <= 1'b1;
                  priority if (det_hit) begin
                    out_status_r <= flwm_pkg::ST_DET_FLAG;
                  end else if (shr_hit) begin
                    out_status_r <= flwm_pkg::ST_SHR_FLAG;
                  end else begin
                    out_status_r <= flwm_pkg::ST_BAD_PIX;
                  end
                end
              end
              flwm_pkg::ACT_TABLE: begin
                out_valid_r  <= 1'b1;
                out_status_r <= flwm_pkg::ST_TBL_WR;
              end
              flwm_pkg::ACT_READ: st_r <= S_RD;
              default: ;
            endcase
          end
        end
        S_RD: begin
          out_valid_r  <= 1'b1;
          out_status_r <= flwm_pkg::ST_READ;
          for (int i = 0; i < NL; i++) begin
            out_acc_r[i] <= lane_rd[i];
          end
          st_r <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            if (quo[flwm_pkg::PIX_W-1:flwm_pkg::GSUB_W] != '0) begin
              out_valid_r  <= 1'b1;
              out_status_r <= flwm_pkg::ST_UNMAPPED;
              st_r         <= S_IDLE;
            end else begin
              st_r <= S_TBL;
            end
          end
        end
        S_TBL: st_r <= S_MAP;
        S_MAP: begin
          if (!tbl_rdata[4]) begin
            out_valid_r  <= 1'b1;
            out_status_r <= flwm_pkg::ST_UNMAPPED;
            st_r         <= S_IDLE;
          end else begin
            st_r <= S_HI;
          end
        end
        S_HI:   st_r <= S_TERM;
        S_TERM: st_r <= S_ADD;
        S_ADD: begin
          out_valid_r  <= 1'b1;
          out_status_r <= flwm_pkg::ST_ADDED;
          st_r         <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_accum_0 = out_acc_r[0];
  assign out_accum_1 = out_acc_r[1];
  assign out_accum_2 = out_acc_r[2];
  assign out_accum_3 = out_acc_r[3];

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
module tb_top;

  typedef struct {
    flwm_pkg::action_t  act;
    logic signed [20:0] pixel;
    logic signed [31:0] value;
    logic signed [31:0] gain;
    logic signed [31:0] w [4];
    logic [7:0]         dflags;
    logic [7:0]         sflags;
    logic [13:0]        addr;
    logic signed [4:0]  entry;
  } item_t;

  typedef struct {
    flwm_pkg::status_t st;
    longint            acc [4];
  } result_t;

  typedef struct {
    item_t             it;
    bit                typed;
    flwm_pkg::status_t st;
  } row_t;

  localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
  localparam int     WATCHDOG = 100000;

  logic clk, rst_n;
  logic start, busy;
  logic [1:0] in_action;
  logic signed [20:0] in_pixel;
  logic signed [31:0] in_sample_value, in_gain;
  logic signed [31:0] in_weight_0, in_weight_1, in_weight_2, in_weight_3;
  logic [7:0] in_det_flag_bits, in_shared_flag_bits;
  logic [13:0] in_entry_address;
  logic signed [4:0] in_entry_value;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [10:0] cfg_data;
  logic out_valid;
  logic [2:0] out_status;
  logic signed [63:0] out_accum_0, out_accum_1, out_accum_2, out_accum_3;

  flagged_weighted_map_accumulator dut (.*);

  // model state
  logic [2:0]  m_count;
  logic [10:0] m_size;
  logic [7:0]  m_dmask, m_smask;
  logic        m_den, m_sen;
  bit          map_ok [flwm_pkg::GLOBAL_SUBMAPS];
  logic [3:0]  map_loc [flwm_pkg::GLOBAL_SUBMAPS];
  longint      pix_acc [flwm_pkg::SLOT_COUNT*flwm_pkg::MAX_COMPONENTS];

  result_t     pending [$];
  int          touched [$];
  int          errors, n_items, n_results, n_cfg;
  int          st_seen [8];
  bit          no_gaps;

  function automatic longint scale_term(longint scaled, longint w);
    bit          neg;
    logic [63:0] a, b;
    logic [127:0] q;
    neg = (scaled < 0) != (w < 0);
    a = scaled < 0 ? 64'd0 - scaled : scaled;
    b = w < 0 ? 64'd0 - w : w;
    if (a == 0 || b == 0) return 0;
    q = (128'(a) * 128'(b) + (128'd1 << 29)) >> 30;
    if (neg) begin
      if (q >= (128'd1 << 63)) return I64_MIN;
      return -longint'(q[63:0]);
    end
    if (q > 128'(I64_MAX)) return I64_MAX;
    return longint'(q[63:0]);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(I64_MAX)) return I64_MAX;
    if (s < 65'(I64_MIN)) return I64_MIN;
    return longint'(s);
  endfunction

  function automatic int size_eff();
    if (m_size < 1) return 1;
    if (m_size > flwm_pkg::MAX_SUBMAP_PIXELS) return flwm_pkg::MAX_SUBMAP_PIXELS;
    return int'(m_size);
  endfunction

  function automatic int count_eff();
    if (m_count < 1) return 1;
    if (m_count > flwm_pkg::MAX_COMPONENTS) return flwm_pkg::MAX_COMPONENTS;
    return int'(m_count);
  endfunction

  function automatic flwm_pkg::status_t bin_sample(item_t it);
    int     sz, gsub, sub, slot;
    longint scaled;
    sz = size_eff();
    if (m_den && (it.dflags & m_dmask) != 0) return flwm_pkg::ST_DET_FLAG;
    if (m_sen && (it.sflags & m_smask) != 0) return flwm_pkg::ST_SHR_FLAG;
    if (it.pixel < 0) return flwm_pkg::ST_BAD_PIX;
    gsub = int'(it.pixel) / sz;
    sub = int'(it.pixel) % sz;
    if (gsub >= flwm_pkg::GLOBAL_SUBMAPS || !map_ok[gsub]) return flwm_pkg::ST_UNMAPPED;
    slot = int'(map_loc[gsub]) * sz + sub;
    if (slot >= flwm_pkg::SLOT_COUNT) return flwm_pkg::ST_UNMAPPED;
    scaled = longint'(it.value) * longint'(it.gain);
    for (int c = 0; c < count_eff(); c++)
      pix_acc[slot*flwm_pkg::MAX_COMPONENTS+c] =
          sat_sum(pix_acc[slot*flwm_pkg::MAX_COMPONENTS+c], scale_term(scaled, it.w[c]));
    touched.push_back(slot);
    if (touched.size() > 64) void'(touched.pop_front());
    return flwm_pkg::ST_ADDED;
  endfunction

  // returns 0 when the item produces no result
  function automatic bit map_step(item_t it, output result_t r);
    r.st = flwm_pkg::ST_ADDED;
    for (int c = 0; c < 4; c++) r.acc[c] = 0;
    case (it.act)
      flwm_pkg::ACT_ACCUM: r.st = bin_sample(it);
      flwm_pkg::ACT_TABLE: begin
        if (it.addr < flwm_pkg::GLOBAL_SUBMAPS) begin
          map_ok[it.addr] = it.entry >= 0;
          map_loc[it.addr] = it.entry >= 0 ? it.entry[3:0] : 4'd0;
        end
        r.st = flwm_pkg::ST_TBL_WR;
      end
      flwm_pkg::ACT_READ: begin
        if (it.addr < flwm_pkg::SLOT_COUNT)
          for (int c = 0; c < flwm_pkg::MAX_COMPONENTS; c++)
            r.acc[c] = pix_acc[int'(it.addr)*flwm_pkg::MAX_COMPONENTS+c];
        r.st = flwm_pkg::ST_READ;
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  function automatic item_t mk(flwm_pkg::action_t act, int pixel, int value, int gain,
                               int w0, int w1, int w2, int w3, int dflags, int sflags,
                               int addr, int entry);
    item_t it;
    it.act = act; it.pixel = 21'(pixel); it.value = value; it.gain = gain;
    it.w[0] = w0; it.w[1] = w1; it.w[2] = w2; it.w[3] = w3;
    it.dflags = 8'(dflags); it.sflags = 8'(sflags);
    it.addr = 14'(addr); it.entry = 5'(entry);
    return it;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_t e;
    logic signed [63:0] got [4];
    if (rst_n && out_valid) begin
      n_results++;
      st_seen[out_status]++;
      got[0] = out_accum_0; got[1] = out_accum_1;
      got[2] = out_accum_2; got[3] = out_accum_3;
      if (pending.size() == 0) begin
        $error("result with nothing expected: status %0d", out_status);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          errors++;
        end
        for (int c = 0; c < 4; c++)
          if (got[c] !== e.acc[c]) begin
            $error("accum_%0d: expected %0d, got %0d", c, e.acc[c], got[c]);
            errors++;
          end
      end
    end
  end

  int quiet;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("status: fail");
      $finish;
    end
  end

  task automatic drive(item_t it, bit typed = 0,
                       flwm_pkg::status_t st = flwm_pkg::ST_ADDED);
    result_t r;
    bit      has;
    in_action = it.act; in_pixel = it.pixel; in_sample_value = it.value;
    in_gain = it.gain; in_weight_0 = it.w[0]; in_weight_1 = it.w[1];
    in_weight_2 = it.w[2]; in_weight_3 = it.w[3];
    in_det_flag_bits = it.dflags; in_shared_flag_bits = it.sflags;
    in_entry_address = it.addr; in_entry_value = it.entry;
    start = 1;
    while (busy) @(negedge clk);
    @(posedge clk);
    n_items++;
    has = map_step(it, r);
    if (has) begin
      if (typed) begin
        r.st = st;
        for (int c = 0; c < 4; c++) r.acc[c] = 0;
      end
      pending.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic pause(int n);
    start = 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start = 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic cfg_write(flwm_pkg::reg_idx_t idx, int data);
    cfg_index = idx; cfg_data = 11'(data); cfg_valid = 1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    n_cfg++;
    case (idx)
      flwm_pkg::REG_COUNT:    m_count = data[2:0];
      flwm_pkg::REG_SIZE:     m_size = data[10:0];
      flwm_pkg::REG_DET_MASK: m_dmask = data[7:0];
      flwm_pkg::REG_SHR_MASK: m_smask = data[7:0];
      flwm_pkg::REG_DET_EN:   m_den = data[0];
      flwm_pkg::REG_SHR_EN:   m_sen = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic configure(int cnt, int sz, int dm, int sm, int de, int se);
    drain();
    cfg_write(flwm_pkg::REG_COUNT, cnt);
    cfg_write(flwm_pkg::REG_SIZE, sz);
    cfg_write(flwm_pkg::REG_DET_MASK, dm);
    cfg_write(flwm_pkg::REG_SHR_MASK, sm);
    cfg_write(flwm_pkg::REG_DET_EN, de);
    cfg_write(flwm_pkg::REG_SHR_EN, se);
  endtask

  function automatic int rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3, 4: return $signed($urandom_range(0, 4095)) - 2048;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    k, sz;
    sz = size_eff();
    k = $urandom_range(0, 99);
    it = mk(flwm_pkg::ACT_ACCUM, 0, rand_word(), rand_word(), rand_word(), rand_word(),
            rand_word(), rand_word(),
            $urandom_range(0, 255) & ($urandom_range(0, 1) ? 8'hff : 8'h00),
            $urandom_range(0, 255), $urandom_range(0, 16383), $urandom_range(0, 31));
    if (k < 14) begin
      it.act = flwm_pkg::ACT_TABLE;
      if ($urandom_range(0, 5) != 0) it.addr = 14'($urandom_range(0, 31));
      if ($urandom_range(0, 3) != 0) it.entry = 5'($urandom_range(0, 15));
    end else if (k < 64) begin
      it.pixel = 21'($urandom_range(0, 31) * sz + $urandom_range(0, sz - 1));
    end else if (k < 74) begin
      it.pixel = 21'($urandom);
    end else if (k < 96) begin
      it.act = flwm_pkg::ACT_READ;
      if (touched.size() != 0 && $urandom_range(0, 4) != 0)
        it.addr = 14'(touched[$urandom_range(0, touched.size() - 1)]);
    end else begin
      it.act = flwm_pkg::ACT_NONE;
    end
    return it;
  endfunction

  row_t directed [$];

  initial begin
    int phase_cfg [8][6];
    rst_n = 0; start = 0; cfg_valid = 0; cfg_index = flwm_pkg::REG_COUNT; cfg_data = 0;
    in_action = flwm_pkg::ACT_NONE; in_pixel = 0; in_sample_value = 0; in_gain = 0;
    in_weight_0 = 0; in_weight_1 = 0; in_weight_2 = 0; in_weight_3 = 0;
    in_det_flag_bits = 0; in_shared_flag_bits = 0; in_entry_address = 0;
    in_entry_value = 0;
    m_count = 1; m_size = 1024; m_dmask = 0; m_smask = 0; m_den = 0; m_sen = 0;
    foreach (map_ok[i]) begin
      map_ok[i] = 0;
      map_loc[i] = 0;
    end
    foreach (pix_acc[i]) pix_acc[i] = 0;

    directed = '{
      '{mk(flwm_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, flwm_pkg::ST_READ},
      '{mk(flwm_pkg::ACT_ACCUM, 5, 7, 65536, 1 << 30, 0, 0, 0, 0, 0, 0, 0), 1,
        flwm_pkg::ST_UNMAPPED},
      '{mk(flwm_pkg::ACT_ACCUM, -1, 7, 65536, 1 << 30, 0, 0, 0, 0, 0, 0, 0), 1,
        flwm_pkg::ST_BAD_PIX},
      '{mk(flwm_pkg::ACT_ACCUM, 1048575, 7, 65536, 1, 0, 0, 0, 0, 0, 0, 0), 1,
        flwm_pkg::ST_UNMAPPED},
      '{mk(flwm_pkg::ACT_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16383, 2), 1,
        flwm_pkg::ST_TBL_WR},
      '{mk(flwm_pkg::ACT_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3), 1, flwm_pkg::ST_TBL_WR},
      '{mk(flwm_pkg::ACT_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, -1), 1, flwm_pkg::ST_TBL_WR},
      '{mk(flwm_pkg::ACT_TABLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 2, 15), 1, flwm_pkg::ST_TBL_WR},
      '{mk(flwm_pkg::ACT_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_ACCUM, 5, 1000, 65536, 1 << 30, 3, 5, 7, 255, 255, 0, 0), 1,
        flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3 * 1024 + 5, 0), 0,
        flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_ACCUM, 1031, 9, 9, 9, 0, 0, 0, 0, 0, 0, 0), 1,
        flwm_pkg::ST_UNMAPPED},
      '{mk(flwm_pkg::ACT_ACCUM, 3071, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h7fff_ffff, 0, 0, 0, 0, 0, 0), 0, flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_ACCUM, 3071, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h7fff_ffff, 0, 0, 0, 0, 0, 0), 0, flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15 * 1024 + 1023, 0), 0,
        flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_ACCUM, 3071, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0,
           0, 0, 0, 0, 0), 0, flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15 * 1024 + 1023, 0), 0,
        flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_ACCUM, 2048, -3, 32'h8000, 32'h2000_0000, 0, 0, 0, 0, 0, 0, 0), 0,
        flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_ACCUM, 2048, 3, 32'h8000, 32'h2000_0000, 0, 0, 0, 0, 0, 0, 0), 0,
        flwm_pkg::ST_ADDED},
      '{mk(flwm_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15 * 1024, 0), 0,
        flwm_pkg::ST_ADDED}
    };

    phase_cfg = '{'{7, 2047, 255, 255, 0, 0}, '{0, 0, 0, 0, 1, 1},
                  '{4, 1, 8'h0f, 8'hf0, 1, 1}, '{2, 37, 8'ha5, 8'h5a, 3, 2},
                  '{3, 512, 1, 128, 0, 1}, '{1, 1024, 8'h80, 8'h01, 1, 0},
                  '{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (directed[i]) drive(directed[i].it, directed[i].typed, directed[i].st);

    for (int p = 0; p < 8; p++) begin
      if (p >= 6)
        for (int j = 0; j < 6; j++) phase_cfg[p][j] = $urandom_range(0, 2047);
      configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                phase_cfg[p][3], phase_cfg[p][4], phase_cfg[p][5]);
      no_gaps = (p == 7);
      for (int n = 0; n < 205; n++) begin
        if (!no_gaps && $urandom_range(0, 5) == 0) pause($urandom_range(1, 12));
        drive(rand_item());
      end
    end

    drain();
    $display("%0d items, %0d results, %0d register writes over 8 settings", n_items,
             n_results, n_cfg);
    $display("added %0d, flagged %0d/%0d, bad %0d, unmapped %0d, table %0d, read %0d",
             st_seen[flwm_pkg::ST_ADDED], st_seen[flwm_pkg::ST_DET_FLAG],
             st_seen[flwm_pkg::ST_SHR_FLAG], st_seen[flwm_pkg::ST_BAD_PIX],
             st_seen[flwm_pkg::ST_UNMAPPED], st_seen[flwm_pkg::ST_TBL_WR],
             st_seen[flwm_pkg::ST_READ]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
